// ----- rtl/forward_max_match_segmenter_defines.svh -----
// assertion macros used by the segmenter back end
`ifndef FORWARD_MAX_MATCH_SEGMENTER_DEFINES_SVH
`define FORWARD_MAX_MATCH_SEGMENTER_DEFINES_SVH

// concurrent check on clk, quiet while rst_n is low
`define FMMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check written as an implication
`define FMMS_ASSERT_IMP(lbl, ante, cons, msg) \
    `FMMS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/fmms_pkg.sv -----
// shared types and constants of the forward maximum matching segmenter
package fmms_pkg;

    localparam int MAX_WORD_LEN_DEF = 8;
    localparam int DICT_ENTRIES_DEF = 256;
    localparam int CHAR_BITS_DEF    = 16;

    localparam logic [3:0] CFG_RESET = 4'd5;

    localparam logic [1:0] OP_LOAD_CHAR = 2'd0;
    localparam logic [1:0] OP_SET_LEN   = 2'd1;
    localparam logic [1:0] OP_SENT_CHAR = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        last;
        logic [7:0]  entry;
        logic [2:0]  pos;
        logic [15:0] code;
    } fmms_cmd_t;

endpackage

// ----- rtl/fmms_front.sv -----
// front end: accepts requests, drops ignored ones, queues the rest
module fmms_front
    import fmms_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fmms_cmd_t in_cmd,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output fmms_cmd_t cmd
);

    fmms_cmd_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep;
    logic       push, pop;
    logic [31:0] ent32, pos32;

    always_comb
    begin
        ent32 = {24'b0, in_cmd.entry};
        pos32 = {29'b0, in_cmd.pos};
        case (in_cmd.op)
            OP_LOAD_CHAR: keep = (ent32 < DICT_ENTRIES) && (pos32 < MAX_WORD_LEN);
            OP_SET_LEN:   keep = (ent32 < DICT_ENTRIES);
            OP_SENT_CHAR: keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/fmms_back.sv -----
// back end: dictionary stores, sentence window and longest match search
`include "forward_max_match_segmenter_defines.svh"
module fmms_back
    import fmms_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int CHAR_BITS    = CHAR_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  max_word_len,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  fmms_cmd_t   cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_status,
    output logic [15:0] out_start,
    output logic [3:0]  out_length,
    output logic        out_last
);

    localparam int IDX_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int POS_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    typedef logic [CHAR_BITS-1:0] char_t;

    // stores
    char_t            dict_mem [DICT_ENTRIES][MAX_WORD_LEN];
    logic [CNT_W-1:0] len_mem  [DICT_ENTRIES];
    logic             len_vld_reg [DICT_ENTRIES];

    // read stage
    char_t            rd_row_reg [MAX_WORD_LEN];
    logic [CNT_W-1:0] rd_len_reg;
    logic             rd_ok_reg;
    logic             rd_vld_reg;

    // control and window
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] best_reg, best_next;
    char_t            win_reg [MAX_WORD_LEN];
    char_t            win_next [MAX_WORD_LEN];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      pos_reg, pos_next;
    logic             disc_reg, disc_next;
    logic             last_reg, last_next;

    logic             ov_reg, ov_next;
    logic             os_reg, os_next;
    logic [15:0]      ost_reg, ost_next;
    logic [3:0]       ol_reg, ol_next;
    logic             olast_reg, olast_next;

    logic [CNT_W-1:0] win_size, lim, m_len, cnt_app, cnt_rem;
    logic             hit, out_free, wr_char, wr_len;
    logic [31:0]      ent32, pos32, code32;
    logic [IDX_W-1:0] wa;
    logic [POS_W-1:0] wp;
    char_t            ch;
    logic [CNT_W-1:0] new_len;

    always_comb
    begin
        if (max_word_len == 4'd0)
            win_size = CNT_W'(1);
        else if ({28'b0, max_word_len} > MAX_WORD_LEN)
            win_size = CNT_W'(MAX_WORD_LEN);
        else
            win_size = CNT_W'(max_word_len);
        lim    = (cnt_reg < win_size) ? cnt_reg : win_size;
        ent32  = {24'b0, cmd.entry};
        pos32  = {29'b0, cmd.pos};
        code32 = {16'b0, cmd.code};
        wa     = ent32[IDX_W-1:0];
        wp     = pos32[POS_W-1:0];
        ch     = code32[CHAR_BITS-1:0];
        new_len = (code32 > MAX_WORD_LEN) ? '0 : CNT_W'(code32);
    end

    // prefix compare of the entry read last cycle
    always_comb
    begin
        m_len = rd_ok_reg ? rd_len_reg : '0;
        hit   = (m_len != '0) && (m_len <= lim);
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            if ((i < m_len) && (rd_row_reg[i] != win_reg[i]))
                hit = 1'b0;
        end
    end

    assign cmd_ready  = (state_reg == S_IDLE);
    assign out_free   = !ov_reg || out_ready;
    assign wr_char    = cmd_valid && cmd_ready && (cmd.op == OP_LOAD_CHAR);
    assign wr_len     = cmd_valid && cmd_ready && (cmd.op == OP_SET_LEN);
    assign cnt_app    = (cnt_reg < MAX_WORD_LEN) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign cnt_rem    = cnt_reg - best_reg;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        best_next  = best_reg;
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        disc_next  = disc_reg;
        last_next  = last_reg;
        ov_next    = ov_reg && !out_ready;
        os_next    = os_reg;
        ost_next   = ost_reg;
        ol_next    = ol_reg;
        olast_next = olast_reg;

        if (rd_vld_reg && hit && (m_len > best_reg))
            best_next = m_len;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_SENT_CHAR))
                begin
                    last_next = cmd.last;
                    if (disc_reg)
                    begin
                        if (cmd.last)
                        begin
                            disc_next = 1'b0;
                            cnt_next  = '0;
                            pos_next  = '0;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_WORD_LEN; i++)
                        begin
                            if (i == cnt_reg)
                                win_next[i] = ch;
                        end
                        cnt_next = cnt_app;
                        if ((cnt_app != '0) && (cmd.last || cnt_app >= win_size))
                        begin
                            state_next = S_SCAN;
                            addr_next  = '0;
                            best_next  = '0;
                        end
                        else if (cmd.last)
                        begin
                            cnt_next = '0;
                            pos_next = '0;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == IDX_W'(DICT_ENTRIES - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    ost_next = pos_reg;
                    ol_next  = 4'(best_reg);
                    if (best_reg == '0)
                    begin
                        // no prefix matched: abandon the sentence
                        os_next    = 1'b1;
                        olast_next = 1'b1;
                        disc_next  = !last_reg;
                        cnt_next   = '0;
                        pos_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        os_next    = 1'b0;
                        olast_next = last_reg && (cnt_rem == '0);
                        for (int i = 0; i < MAX_WORD_LEN; i++)
                        begin
                            for (int j = 0; j < MAX_WORD_LEN; j++)
                            begin
                                if (j == i + best_reg)
                                    win_next[i] = win_reg[j];
                            end
                        end
                        cnt_next = cnt_rem;
                        pos_next = pos_reg + 16'(best_reg);
                        if ((cnt_rem != '0) && (last_reg || cnt_rem >= win_size))
                        begin
                            state_next = S_SCAN;
                            addr_next  = '0;
                            best_next  = '0;
                        end
                        else
                        begin
                            if (last_reg)
                            begin
                                cnt_next = '0;
                                pos_next = '0;
                            end
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            addr_reg   <= '0;
            best_reg   <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            disc_reg   <= 1'b0;
            last_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            best_reg   <= best_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            disc_reg   <= disc_next;
            last_reg   <= last_next;
            ov_reg     <= ov_next;
            rd_vld_reg <= (state_reg == S_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        os_reg    <= os_next;
        ost_reg   <= ost_next;
        ol_reg    <= ol_next;
        olast_reg <= olast_next;
    end

    // entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < DICT_ENTRIES; e++)
                len_vld_reg[e] <= 1'b0;
        end
        else if (wr_len)
        begin
            len_vld_reg[wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_char)
            dict_mem[wa][wp] <= ch;
        if (wr_len)
            len_mem[wa] <= new_len;
        rd_row_reg <= dict_mem[addr_reg];
        rd_len_reg <= len_mem[addr_reg];
        rd_ok_reg  <= len_vld_reg[addr_reg];
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_start  = ost_reg;
    assign out_length = ol_reg;
    assign out_last   = olast_reg;

    `FMMS_ASSERT(a_cnt_bound, cnt_reg <= MAX_WORD_LEN, "window count past capacity")
    `FMMS_ASSERT_IMP(a_disc_empty, disc_reg, cnt_reg == '0, "discarding with filled window")
    `FMMS_ASSERT_IMP(a_err_len, ov_reg && os_reg, ol_reg == 4'd0 && olast_reg, "bad error result")
    `FMMS_ASSERT_IMP(a_load_src, $rose(ov_reg), $past(state_reg) == S_EMIT, "result from wrong state")

endmodule

// ----- rtl/forward_max_match_segmenter.sv -----
// top level of the forward maximum matching word segmenter
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tuser operation, tdata index/pos/code, tlast last
// m_*       out  m_tvalid / m_tready     tuser status, tdata start/length, tlast sentence end
// cfg_*     in   cfg_valid / cfg_ready   max_word_len
//
// load requests are written into the back end stores when they leave the two-entry queue
// each word search reads every dictionary entry once through the single dictionary read port,
// and the back end takes no new request until the search ends and its result is registered
// reset clears the window count, the entry valid bits and the queue; no clearing pass is needed
// a stalled m_tready holds the back end in its emit step while the queue fills its two entries
module forward_max_match_segmenter
    import fmms_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int CHAR_BITS    = CHAR_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index [7:0], char_pos [10:8], code [26:11]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // word_start [15:0], word_length [19:16]
    output logic        m_tuser,   // status [0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // max_word_len [3:0]
);

    fmms_cmd_t   in_cmd, cmd;
    logic        cmd_valid, cmd_ready;
    logic [3:0]  mwl_reg;
    logic [15:0] out_start;
    logic [3:0]  out_length;

    // window size register, taken on every write; the sender writes it only while idle
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mwl_reg <= CFG_RESET;
        else if (cfg_valid)
            mwl_reg <= cfg_data;
    end

    // unpack the request
    always_comb
    begin
        in_cmd.op    = s_tuser;
        in_cmd.last  = s_tlast;
        in_cmd.entry = s_tdata[7:0];
        in_cmd.pos   = s_tdata[10:8];
        in_cmd.code  = s_tdata[26:11];
    end

    fmms_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fmms_back #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .DICT_ENTRIES (DICT_ENTRIES),
        .CHAR_BITS    (CHAR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_word_len (mwl_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (m_tuser),
        .out_start    (out_start),
        .out_length   (out_length),
        .out_last     (m_tlast)
    );

    // pack the result, unused upper bits zero
    assign m_tdata = {4'b0, out_length, out_start};

endmodule

// ----- dv/fmms_checker.sv -----
// watches the segmenter channels, predicts the word results and compares them
module fmms_checker
    import fmms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic        status;
        logic [15:0] start;
        logic [3:0]  length;
        logic        last;
    } word_result_t;

    word_result_t expected_words[$];

    logic [15:0] dict_chars [DICT_ENTRIES_DEF][MAX_WORD_LEN_DEF];
    logic [3:0]  entry_len  [DICT_ENTRIES_DEF];
    logic [15:0] window     [MAX_WORD_LEN_DEF];
    int          win_count;
    logic [15:0] sent_pos;
    logic        skipping;
    logic [3:0]  word_len_reg;

    function automatic int window_size();
        if (word_len_reg == 0) return 1;
        if (word_len_reg > MAX_WORD_LEN_DEF) return MAX_WORD_LEN_DEF;
        return word_len_reg;
    endfunction

    function automatic int longest_match();
        int len;
        bit hit;
        len = (win_count < window_size()) ? win_count : window_size();
        for (; len > 0; len--) begin
            for (int e = 0; e < DICT_ENTRIES_DEF; e++) begin
                if (entry_len[e] == len) begin
                    hit = 1;
                    for (int i = 0; i < len; i++)
                        if (dict_chars[e][i] != window[i]) hit = 0;
                    if (hit) return len;
                end
            end
        end
        return 0;
    endfunction

    task automatic segment_request(logic [1:0] op, logic [7:0] idx, logic [2:0] pos,
                                   logic [15:0] code, logic last);
        int len;
        word_result_t r;
        if (op == OP_LOAD_CHAR) begin
            dict_chars[idx][pos] = code;
            return;
        end
        if (op == OP_SET_LEN) begin
            entry_len[idx] = (code > MAX_WORD_LEN_DEF) ? 4'd0 : code[3:0];
            return;
        end
        if (op != OP_SENT_CHAR) return;
        if (skipping) begin
            if (last) begin
                skipping  = 0;
                win_count = 0;
                sent_pos  = 0;
            end
            return;
        end
        if (win_count < MAX_WORD_LEN_DEF) begin
            window[win_count] = code;
            win_count++;
        end
        while (win_count > 0 && (last || win_count >= window_size())) begin
            len = longest_match();
            if (len == 0) begin
                r = '{status: 1'b1, start: sent_pos, length: 4'd0, last: 1'b1};
                expected_words.insert(expected_words.size(), r);
                if (!last) skipping = 1;
                win_count = 0;
                sent_pos  = 0;
                return;
            end
            for (int i = 0; i + len < MAX_WORD_LEN_DEF; i++) window[i] = window[i + len];
            win_count -= len;
            r = '{status: 1'b0, start: sent_pos, length: len[3:0],
                  last: (last && win_count == 0)};
            expected_words.insert(expected_words.size(), r);
            sent_pos = sent_pos + len[15:0];
        end
        if (last) begin
            win_count = 0;
            sent_pos  = 0;
        end
    endtask

    initial
    begin
        errors       = 0;
        win_count    = 0;
        sent_pos     = 0;
        skipping     = 0;
        word_len_reg = CFG_RESET;
        foreach (entry_len[e]) entry_len[e] = 0;
        foreach (window[i]) window[i] = 0;
        foreach (dict_chars[e, i]) dict_chars[e][i] = 0;
    end

    assign pending = expected_words.size();

    always @(posedge clk)
    begin
        word_result_t exp_r;
        word_result_t got;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) word_len_reg = cfg_data;
            if (s_tvalid && s_tready)
                segment_request(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[26:11], s_tlast);
            if (m_tvalid && m_tready) begin
                got = '{status: m_tuser, start: m_tdata[15:0], length: m_tdata[19:16],
                        last: m_tlast};
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_words.pop_front();
                    if (got !== exp_r || m_tdata[23:20] !== 4'd0) begin
                        $display("%0t: result mismatch, expected %p, actual %p (tdata %h)",
                                 $time, exp_r, got, m_tdata);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb.sv -----
// testbench top: drives dictionary loads, sentences and config writes into the segmenter
module tb;
    import fmms_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // entry_index [7:0], char_pos [10:8], code [26:11]
    logic [1:0]  s_tuser;    // operation [1:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // word_start [15:0], word_length [19:16]
    logic        m_tuser;    // status [0]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;   // max_word_len [3:0]

    int          mismatches;
    int          words_pending;
    int          stuck_cycles;
    bit          calm;        // no idling on either side while set
    bit          m_taken;
    int          m_hold;
    logic [7:0]  written [256];   // which characters of each entry hold a loaded value

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 100;
    localparam logic [15:0] CH_A = 16'h0041;

    forward_max_match_segmenter dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    fmms_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(mismatches), .pending(words_pending)
    );

    always #5 clk = ~clk;

    // result side back-pressure: a fresh stall length after every accepted result
    always @(posedge clk) m_taken = m_tvalid && m_tready;

    always @(negedge clk)
    begin
        if (m_taken) m_hold = calm ? 0 : $urandom_range(0, 16);
        if (m_hold > 0) begin
            m_tready = 0;
            m_hold--;
        end else begin
            m_tready = 1;
        end
    end

    // watchdog: any accepted request, result or config write resets the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request on the input stream, with a random gap before it unless calm is set
    task automatic send(logic [1:0] op, logic [7:0] idx, logic [2:0] pos,
                        logic [15:0] code, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {5'd0, code, pos, idx};
        s_tuser  = op;
        s_tlast  = last;
        s_tvalid = 1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic load_char(logic [7:0] idx, logic [2:0] pos, logic [15:0] code);
        written[idx][pos] = 1'b1;
        send(OP_LOAD_CHAR, idx, pos, code, 1'($urandom_range(0, 1)));
    endtask

    // loads a whole word and then enables the entry
    task automatic load_word(logic [7:0] idx, int len, logic [15:0] chars[8]);
        for (int i = 0; i < len; i++) load_char(idx, i[2:0], chars[i]);
        send(OP_SET_LEN, idx, 3'($urandom), 16'(len), 1'b0);
    endtask

    // sets a length, but only enables entries whose characters are all loaded
    task automatic set_length(logic [7:0] idx, logic [15:0] len);
        logic [15:0] safe;
        safe = len;
        if (len >= 1 && len <= 8 && (written[idx] & 8'((1 << len) - 1)) != 8'((1 << len) - 1))
            safe = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(9, 65535));
        send(OP_SET_LEN, idx, 3'($urandom), safe, 1'b0);
    endtask

    // register writes only when the block has nothing left to deliver
    task automatic write_word_len(logic [3:0] v);
        s_tvalid = 0;
        while (words_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data  = v;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic sentence(string s);
        for (int i = 0; i < s.len(); i++)
            send(OP_SENT_CHAR, 8'($urandom), 3'($urandom), 16'(s[i]), i == s.len() - 1);
    endtask

    initial
    begin
        logic [15:0] w[8];
        int          n;
        int          len;
        int          sel;
        logic [15:0] c;
        clk       = 0;
        rst_n     = 0;
        calm      = 0;
        m_taken   = 0;
        m_hold    = 0;
        m_tready  = 0;
        s_tvalid  = 0;
        s_tdata   = 0;
        s_tuser   = 0;
        s_tlast   = 0;
        cfg_valid = 0;
        cfg_data  = 0;
        stuck_cycles = 0;
        foreach (written[e]) written[e] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;

        // directed: small dictionary over A..D
        w = '{CH_A, CH_A + 16'd1, CH_A + 16'd2, CH_A + 16'd3,
              CH_A, CH_A + 16'd1, CH_A + 16'd2, CH_A + 16'd3};
        load_word(8'd0, 1, w);                  // A
        load_word(8'd1, 2, w);                  // AB
        load_word(8'd2, 8, w);                  // ABCDABCD, longest word
        w[0] = CH_A + 16'd1;
        load_word(8'd3, 1, w);                  // B
        w[0] = CH_A + 16'd2;
        load_word(8'd4, 1, w);                  // C
        w[0] = CH_A + 16'd3;
        load_word(8'd255, 1, w);                // D
        send(OP_RESERVED, 8'hff, 3'd7, 16'hffff, 1'b1);   // unknown operation, ignored
        sentence("ABCDABCDA");                  // window of 5 cannot reach the long word
        sentence("AXB");                        // no match, rest of sentence discarded
        sentence("C");                          // single character sentence
        write_word_len(4'd8);
        sentence("ABCDABCDAB");                 // full-length word
        write_word_len(4'd0);                   // acts as one
        sentence("ABD");
        send(OP_SET_LEN, 8'd3, 3'd0, 16'd9, 1'b0); // overlong length disables B
        send(OP_SENT_CHAR, 8'd0, 3'd0, CH_A, 1'b0);
        send(OP_SENT_CHAR, 8'd0, 3'd0, CH_A + 16'd1, 1'b0);  // error, then discarding
        send(OP_SENT_CHAR, 8'd0, 3'd0, 16'hffff, 1'b1);
        write_word_len(4'd15);                  // above the maximum acts as eight
        send(OP_SENT_CHAR, 8'd0, 3'd0, CH_A, 1'b0);
        send(OP_SENT_CHAR, 8'd0, 3'd0, CH_A + 16'd2, 1'b0);
        send(OP_SENT_CHAR, 8'd0, 3'd0, CH_A, 1'b0);
        write_word_len(4'd1);                   // shrink with three characters held
        send(OP_SENT_CHAR, 8'd0, 3'd0, CH_A, 1'b1);
        send(OP_SET_LEN, 8'd3, 3'd0, 16'd1, 1'b0);

        // random: mostly well-formed sentences over the alphabet, some loads and noise
        n = 0;
        while (n < 250) begin
            if (n % 50 == 0) begin
                write_word_len(4'($urandom_range(0, 15)));
                calm = ($urandom_range(0, 3) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                c = $urandom_range(0, 3) == 0 ? 16'($urandom) : CH_A + 16'($urandom_range(0, 4));
                load_char(8'($urandom_range(5, 254)), 3'($urandom), c);
                n++;
            end else if (sel < 20) begin
                set_length(8'($urandom_range(5, 255)),
                           $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8)));
                n++;
            end else if (sel < 22) begin
                send(OP_RESERVED, 8'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    c = $urandom_range(0, 11) == 0 ? 16'($urandom)
                                                   : CH_A + 16'($urandom_range(0, 4));
                    send(OP_SENT_CHAR, 8'($urandom), 3'($urandom), c, i == len - 1);
                    n++;
                end
            end
        end
        write_word_len(4'd5);
        sentence("ABCA");
        s_tvalid = 0;

        while (words_pending != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (mismatches == 0 && words_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- forward_max_match_segmenter.f -----
+incdir+rtl
rtl/fmms_pkg.sv
rtl/fmms_front.sv
rtl/fmms_back.sv
rtl/forward_max_match_segmenter.sv
dv/fmms_checker.sv
dv/tb.sv
